// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and status codes for the JSON string unescape block.
`default_nettype none

package jsu_pkg;

  localparam logic [3:0] ST_BYTE        = 4'd0;
  localparam logic [3:0] ST_DONE        = 4'd1;
  localparam logic [3:0] ST_NO_QUOTE    = 4'd2;
  localparam logic [3:0] ST_CTRL_CHAR   = 4'd3;
  localparam logic [3:0] ST_UNTERM_ESC  = 4'd4;
  localparam logic [3:0] ST_BAD_ESC     = 4'd5;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd6;
  localparam logic [3:0] ST_BAD_HEX     = 4'd7;
  localparam logic [3:0] ST_SURROGATE   = 4'd8;
  localparam logic [3:0] ST_UNTERM_STR  = 4'd9;

  localparam int unsigned GROUP_MAX = 3;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [3:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [GROUP_MAX-1:0]    res;
  } group_t;

endpackage

`default_nettype wire

// ===== hw/rtl/json_string_unescape.sv =====
// Top level of the JSON string literal decoder with stream ports.
//
//  Channel   Dir  tdata              tuser                      tlast
//  s_*       in   in_byte[7:0]       text_end                   -
//  m_*       out  out_byte[7:0]      has_byte[0], status[4:1]   last
//
// One request is taken per cycle while the queue has room; its results leave the queue
// one per cycle while the output is ready. A request yielding several bytes fills the
// result queue, and the input is refused while more than one result is queued.
// Reset returns the parser to waiting for an opening quote and empties the queue.
// A stalled output only stalls the input once the four-entry queue holds two results.
`default_nettype none

module json_string_unescape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // [0] text_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic [4:0]       m_tuser,   // [0] has_byte, [4:1] status
  output logic             m_tlast
);

  jsu_pkg::group_t  group;
  jsu_pkg::result_t res;
  logic             take;

  assign take = s_tvalid && s_tready;

  jsu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (s_tdata),
    .text_end (s_tuser),
    .group    (group)
  );

  jsu_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .group     (group),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = res.out_byte;
  assign m_tuser = {res.status, res.has_byte};
  assign m_tlast = res.last;

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_decode.sv =====
// Literal decoder: parser state registers and the per-byte next-state and result logic.
`default_nettype none

module jsu_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    in_byte,
  input  wire logic          text_end,
  output jsu_pkg::group_t    group
);

  typedef enum logic [1:0] {PH_WAIT, PH_STR, PH_ESC, PH_HEX} phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;

  logic [4:0]  hex_digit;
  logic [15:0] code_point;

  always_comb begin
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_digit = {1'b0, in_byte[3:0]};
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_digit = {1'b0, in_byte[3:0] + 4'd9};
    end else begin
      hex_digit = 5'd16;
    end
  end

  assign code_point = {code_accum[11:0], hex_digit[3:0]};

  function automatic jsu_pkg::result_t byte_res(input logic [7:0] b, input logic lst);
    jsu_pkg::result_t r;
    r.out_byte = b;
    r.has_byte = 1'b1;
    r.status   = jsu_pkg::ST_BYTE;
    r.last     = lst;
    return r;
  endfunction

  function automatic jsu_pkg::result_t fail_res(input logic [3:0] st);
    jsu_pkg::result_t r;
    r.out_byte = 8'd0;
    r.has_byte = 1'b0;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  always_comb begin
    phase_next      = phase;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    group           = '0;
    unique case (phase)
      PH_WAIT: begin
        if (text_end || in_byte != 8'h22) begin
          group.cnt    = 2'd1;
          group.res[0] = fail_res(jsu_pkg::ST_NO_QUOTE);
        end else begin
          phase_next = PH_STR;
        end
      end
      PH_STR: begin
        group.cnt = 2'd1;
        if (text_end) begin
          group.res[0] = fail_res(jsu_pkg::ST_UNTERM_STR);
          phase_next   = PH_WAIT;
        end else if (in_byte == 8'h22) begin
          group.res[0] = fail_res(jsu_pkg::ST_DONE);
          phase_next   = PH_WAIT;
        end else if (in_byte < 8'h20) begin
          group.res[0] = fail_res(jsu_pkg::ST_CTRL_CHAR);
          phase_next   = PH_WAIT;
        end else if (in_byte == 8'h5C) begin
          group.cnt  = 2'd0;
          phase_next = PH_ESC;
        end else begin
          group.res[0] = byte_res(in_byte, 1'b1);
        end
      end
      PH_ESC: begin
        group.cnt  = 2'd1;
        phase_next = PH_STR;
        if (text_end) begin
          group.res[0] = fail_res(jsu_pkg::ST_UNTERM_ESC);
          phase_next   = PH_WAIT;
        end else begin
          case (in_byte)
            8'h22:   group.res[0] = byte_res(8'h22, 1'b1);
            8'h5C:   group.res[0] = byte_res(8'h5C, 1'b1);
            8'h2F:   group.res[0] = byte_res(8'h2F, 1'b1);
            8'h62:   group.res[0] = byte_res(8'h08, 1'b1);
            8'h66:   group.res[0] = byte_res(8'h0C, 1'b1);
            8'h6E:   group.res[0] = byte_res(8'h0A, 1'b1);
            8'h72:   group.res[0] = byte_res(8'h0D, 1'b1);
            8'h74:   group.res[0] = byte_res(8'h09, 1'b1);
            8'h75: begin
              group.cnt       = 2'd0;
              phase_next      = PH_HEX;
              hex_count_next  = 2'd0;
              code_accum_next = 16'd0;
            end
            default: begin
              group.res[0] = fail_res(jsu_pkg::ST_BAD_ESC);
              phase_next   = PH_WAIT;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (text_end || hex_digit[4]) begin
          group.cnt       = 2'd1;
          group.res[0]    = fail_res(text_end ? jsu_pkg::ST_INCOMPLETE : jsu_pkg::ST_BAD_HEX);
          phase_next      = PH_WAIT;
          hex_count_next  = 2'd0;
          code_accum_next = 16'd0;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_accum_next = code_point;
        end else begin
          hex_count_next  = 2'd0;
          code_accum_next = 16'd0;
          phase_next      = PH_STR;
          if (code_point >= 16'hD800 && code_point <= 16'hDFFF) begin
            group.cnt    = 2'd1;
            group.res[0] = fail_res(jsu_pkg::ST_SURROGATE);
            phase_next   = PH_WAIT;
          end else if (code_point <= 16'h007F) begin
            group.cnt    = 2'd1;
            group.res[0] = byte_res(code_point[7:0], 1'b1);
          end else if (code_point <= 16'h07FF) begin
            group.cnt    = 2'd2;
            group.res[0] = byte_res({3'b110, code_point[10:6]}, 1'b0);
            group.res[1] = byte_res({2'b10, code_point[5:0]}, 1'b1);
          end else begin
            group.cnt    = 2'd3;
            group.res[0] = byte_res({4'b1110, code_point[15:12]}, 1'b0);
            group.res[1] = byte_res({2'b10, code_point[11:6]}, 1'b0);
            group.res[2] = byte_res({2'b10, code_point[5:0]}, 1'b1);
          end
        end
      end
      default: phase_next = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      hex_count  <= 2'd0;
      code_accum <= 16'd0;
    end else if (take) begin
      phase      <= phase_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_result_fifo.sv =====
// Result queue: takes up to three results at once and delivers one per cycle of out_ready.
`default_nettype none

module jsu_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jsu_pkg::group_t group,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output jsu_pkg::result_t    out_res
);

  localparam int unsigned PtrW = $clog2(jsu_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(jsu_pkg::FIFO_DEPTH + 1);

  jsu_pkg::result_t mem [jsu_pkg::FIFO_DEPTH];

  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [1:0]      push_cnt;

  assign pop       = out_valid && out_ready;
  assign push_cnt  = push ? group.cnt : 2'd0;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign room      = (count <= CntW'(jsu_pkg::FIFO_DEPTH - jsu_pkg::GROUP_MAX));
  assign count_next = count + CntW'(push_cnt) - CntW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < jsu_pkg::GROUP_MAX; i++) begin
      if (push && 2'(i) < group.cnt) begin
        mem[wr_ptr + PtrW'(i)] <= group.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_cnt);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(jsu_pkg::FIFO_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    (push && group.cnt != 2'd0) |-> room)
    else $error("Results pushed without room for a full group.");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    (count == CntW'(1) && pop && push_cnt == 2'd0) |=> !out_valid)
    else $error("Queue still shows a result after its only entry was taken.");

  a_ptr_gap : assert property (@(posedge clk) disable iff (rst)
    (count != CntW'(jsu_pkg::FIFO_DEPTH)) |-> (PtrW'(wr_ptr - rd_ptr) == PtrW'(count)))
    else $error("Queue pointers disagree with the count.");

endmodule

`default_nettype wire
